FILE: rtl/srcd_pkg.sv
// ----------------------------------------------------------------------------
// srcd_pkg
// Shared constants, types and the CRC-8 update for the response deframer.
// ----------------------------------------------------------------------------
package srcd_pkg;

    localparam logic [7:0]  CRC_INIT  = 8'hFF;
    localparam logic [7:0]  CRC_POLY  = 8'h31;

    // response_kind register codes
    localparam logic        KIND_MEAS = 1'b0;
    localparam logic        KIND_LONG = 1'b1;

    localparam logic [3:0]  MEAS_WORDS = 4'd8;
    localparam logic [3:0]  LONG_WORDS = 4'd2;

    // byte position within a group
    localparam logic [1:0]  POS_HIGH = 2'd0;
    localparam logic [1:0]  POS_LOW  = 2'd1;
    localparam logic [1:0]  POS_CRC  = 2'd2;

    localparam logic [15:0] SENT_UNSIGNED = 16'hFFFF;
    localparam logic [15:0] SENT_SIGNED   = 16'h7FFF;
    localparam logic signed [21:0] SENT_SCALED = -22'sd200;

    // last unsigned (particulate) word index, and the two special signed ones
    localparam logic [2:0]  IDX_LAST_UNSIGNED = 3'd3;
    localparam logic [2:0]  IDX_DIV100        = 3'd4;
    localparam logic [2:0]  IDX_DIV200        = 3'd5;

    typedef struct packed {
        logic               unavailable;
        logic signed [21:0] value;
    } t_scale_res;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/srcd_in_if.sv
// ----------------------------------------------------------------------------
// srcd_in_if
// Byte channel into the deframer: valid/ready with frame-start flag.
// ----------------------------------------------------------------------------
interface srcd_in_if;
    logic       valid;
    logic       ready;
    logic       first;
    logic [7:0] data_byte;

    modport source (output valid, output first, output data_byte, input ready);
    modport sink   (input valid, input first, input data_byte, output ready);
endinterface

FILE: rtl/srcd_out_if.sv
// ----------------------------------------------------------------------------
// srcd_out_if
// Word channel out of the deframer: valid/ready with decoded word fields.
// ----------------------------------------------------------------------------
interface srcd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         word_index;
    logic [15:0]        raw_word;
    logic               crc_ok;
    logic               unavailable;
    logic signed [21:0] scaled_value;
    logic [31:0]        long_value;
    logic               frame_ok;
    logic               last;

    modport source (output valid, output word_index, output raw_word, output crc_ok,
                    output unavailable, output scaled_value, output long_value,
                    output frame_ok, output last, input ready);
    modport sink   (input valid, input word_index, input raw_word, input crc_ok,
                    input unavailable, input scaled_value, input long_value,
                    input frame_ok, input last, output ready);
endinterface

FILE: rtl/sensor_response_crc_deframer_core.sv
// ----------------------------------------------------------------------------
// sensor_response_crc_deframer_core
// Groups response bytes into CRC-checked words and decodes them.
// ----------------------------------------------------------------------------
// One byte is taken per clock. A byte passes an input register, then the CRC
// update, word assembly and scaling run combinationally into the result
// register. Bytes that complete no word keep flowing while a result waits in
// the result register; only a CRC byte that finds the result register still
// occupied holds the input register, and with it the input channel.
module sensor_response_crc_deframer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    srcd_in_if.sink           i_in,
    srcd_out_if.source        o_out
);

    // configuration and input register
    logic        r_kind;
    logic        r_in_valid;
    logic        r_in_first;
    logic [7:0]  r_in_byte;

    // deframing state
    logic [1:0]  r_pos,   n_pos;
    logic [3:0]  r_count, n_count;
    logic [7:0]  r_crc,   n_crc;
    logic [7:0]  r_high,  n_high;
    logic [7:0]  r_low,   n_low;
    logic        r_err,   n_err;
    logic [15:0] r_upper, n_upper;

    // result register
    logic               r_out_valid;
    logic [2:0]         r_word_index;
    logic [15:0]        r_raw_word;
    logic               r_crc_ok;
    logic               r_unavailable;
    logic signed [21:0] r_scaled_value;
    logic [31:0]        r_long_value;
    logic               r_frame_ok;
    logic               r_last;

    logic [3:0]  frame_len;
    logic [1:0]  pos_eff;
    logic [3:0]  count_eff;
    logic [7:0]  crc_eff;
    logic        err_eff;
    logic        open_frame;
    logic        emit;
    logic        out_free;
    logic        advance;
    logic [15:0] word;
    logic [2:0]  idx;
    logic        ok;
    logic        is_last;
    logic [31:0] long_v;
    logic        unav_v;
    logic signed [21:0] scaled_v;
    srcd_pkg::t_scale_res scale_res;

    assign frame_len = (r_kind == srcd_pkg::KIND_LONG) ? srcd_pkg::LONG_WORDS
                                                       : srcd_pkg::MEAS_WORDS;

    // a frame-start byte restarts the group and frame before anything else
    assign pos_eff   = r_in_first ? srcd_pkg::POS_HIGH : r_pos;
    assign count_eff = r_in_first ? 4'd0 : r_count;
    assign crc_eff   = r_in_first ? srcd_pkg::CRC_INIT : r_crc;
    assign err_eff   = r_in_first ? 1'b0 : r_err;

    assign open_frame = (count_eff < frame_len);
    assign emit       = r_in_valid && open_frame && (pos_eff == srcd_pkg::POS_CRC);
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || advance;

    assign word    = {r_high, r_low};
    assign idx     = count_eff[2:0];
    assign ok      = (crc_eff == r_in_byte);
    assign is_last = ((count_eff + 4'd1) == frame_len);

    srcd_word_scaler u_scaler (
        .i_idx  (idx),
        .i_word (word),
        .o_res  (scale_res)
    );

    always_comb begin
        long_v   = 32'd0;
        unav_v   = 1'b0;
        scaled_v = '0;
        if (r_kind == srcd_pkg::KIND_LONG) begin
            if (idx != 3'd0) begin
                long_v = {r_upper, word};
            end
        end else begin
            unav_v   = scale_res.unavailable;
            scaled_v = scale_res.value;
        end
    end

    always_comb begin
        n_pos   = pos_eff;
        n_count = count_eff;
        n_crc   = crc_eff;
        n_err   = err_eff;
        n_high  = r_high;
        n_low   = r_low;
        n_upper = r_upper;
        if (open_frame) begin
            case (pos_eff)
                srcd_pkg::POS_HIGH: begin
                    n_high = r_in_byte;
                    n_crc  = srcd_pkg::crc8_update(crc_eff, r_in_byte);
                    n_pos  = srcd_pkg::POS_LOW;
                end
                srcd_pkg::POS_LOW: begin
                    n_low = r_in_byte;
                    n_crc = srcd_pkg::crc8_update(crc_eff, r_in_byte);
                    n_pos = srcd_pkg::POS_CRC;
                end
                default: begin
                    n_err   = err_eff || !ok;
                    n_count = count_eff + 4'd1;
                    n_pos   = srcd_pkg::POS_HIGH;
                    n_crc   = srcd_pkg::CRC_INIT;
                    if (r_kind == srcd_pkg::KIND_LONG && idx == 3'd0) begin
                        n_upper = word;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= srcd_pkg::KIND_MEAS;
            r_in_valid  <= 1'b0;
            r_pos       <= srcd_pkg::POS_HIGH;
            r_count     <= srcd_pkg::MEAS_WORDS;
            r_crc       <= srcd_pkg::CRC_INIT;
            r_high      <= 8'd0;
            r_low       <= 8'd0;
            r_err       <= 1'b0;
            r_upper     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_kind <= i_cfg_wr_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_pos   <= n_pos;
                r_count <= n_count;
                r_crc   <= n_crc;
                r_high  <= n_high;
                r_low   <= n_low;
                r_err   <= n_err;
                r_upper <= n_upper;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_first <= i_in.first;
            r_in_byte  <= i_in.data_byte;
        end
        if (advance && emit) begin
            r_word_index   <= idx;
            r_raw_word     <= word;
            r_crc_ok       <= ok;
            r_unavailable  <= unav_v;
            r_scaled_value <= scaled_v;
            r_long_value   <= long_v;
            r_frame_ok     <= is_last && !(err_eff || !ok);
            r_last         <= is_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.word_index   = r_word_index;
    assign o_out.raw_word     = r_raw_word;
    assign o_out.crc_ok       = r_crc_ok;
    assign o_out.unavailable  = r_unavailable;
    assign o_out.scaled_value = r_scaled_value;
    assign o_out.long_value   = r_long_value;
    assign o_out.frame_ok     = r_frame_ok;
    assign o_out.last         = r_last;

endmodule

FILE: rtl/srcd_word_scaler.sv
// ----------------------------------------------------------------------------
// srcd_word_scaler
// Converts a measurement word to units of 1/200 and flags the sentinel.
// ----------------------------------------------------------------------------
module srcd_word_scaler (
    input  logic [2:0]           i_idx,
    input  logic [15:0]          i_word,
    output srcd_pkg::t_scale_res o_res
);

    logic               is_unsigned;
    logic signed [21:0] ext;
    logic signed [21:0] times2;
    logic signed [21:0] times20;

    assign is_unsigned = (i_idx <= srcd_pkg::IDX_LAST_UNSIGNED);
    assign ext     = is_unsigned ? $signed({6'b0, i_word})
                                 : $signed({{6{i_word[15]}}, i_word});
    assign times2  = ext <<< 1;
    // x*20 = x*16 + x*4
    assign times20 = (ext <<< 4) + (ext <<< 2);

    always_comb begin
        o_res.unavailable = 1'b0;
        o_res.value       = times20;
        if (is_unsigned) begin
            if (i_word == srcd_pkg::SENT_UNSIGNED) begin
                o_res.unavailable = 1'b1;
                o_res.value       = srcd_pkg::SENT_SCALED;
            end
        end else if (i_word == srcd_pkg::SENT_SIGNED) begin
            o_res.unavailable = 1'b1;
            o_res.value       = srcd_pkg::SENT_SCALED;
        end else if (i_idx == srcd_pkg::IDX_DIV100) begin
            o_res.value = times2;
        end else if (i_idx == srcd_pkg::IDX_DIV200) begin
            o_res.value = ext;
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the CRC-checked response deframer. Response bytes are sent on
// the byte channel with random gaps. A software copy of the deframer predicts
// every decoded word. Words on the word channel are checked field by field, in
// order, against those predictions. The sequence is directed cases, a
// back-pressure run and random frames with kind switches.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;

    typedef struct packed {
        logic [2:0]         word_index;
        logic [15:0]        raw_word;
        logic               crc_ok;
        logic               unavailable;
        logic signed [21:0] scaled_value;
        logic [31:0]        long_value;
        logic               frame_ok;
        logic               last;
    } t_word_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    srcd_in_if  byte_ch ();
    srcd_out_if word_ch ();

    sensor_response_crc_deframer_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (byte_ch),
        .o_out        (word_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Deframer shadow state
    logic        kind_shadow   = srcd_pkg::KIND_MEAS;
    logic [1:0]  grp_pos       = srcd_pkg::POS_HIGH;
    logic [3:0]  words_done    = srcd_pkg::MEAS_WORDS;
    logic [7:0]  crc_acc       = srcd_pkg::CRC_INIT;
    logic [7:0]  hi_byte       = 8'h00;
    logic [7:0]  lo_byte       = 8'h00;
    logic        crc_fail_seen = 1'b0;
    logic [15:0] upper_half    = 16'h0000;

    t_word_result expected_words[$];
    int error_count      = 0;
    int bytes_used       = 0;
    int idle_pct         = 10;
    int hold_off_request = 0;
    int cycle_count      = 0;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? srcd_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Advance the shadow deframer by one byte; return 1 when a word completes.
    function automatic bit deframe_byte(input logic start_flag, input logic [7:0] b,
                                        output t_word_result r);
        logic [3:0]  frame_len;
        logic [15:0] w;
        int          s;
        r = '0;
        frame_len = (kind_shadow == srcd_pkg::KIND_LONG) ? srcd_pkg::LONG_WORDS
                                                         : srcd_pkg::MEAS_WORDS;
        if (start_flag) begin
            grp_pos       = srcd_pkg::POS_HIGH;
            words_done    = 4'd0;
            crc_acc       = srcd_pkg::CRC_INIT;
            crc_fail_seen = 1'b0;
        end
        if (words_done >= frame_len) return 1'b0;
        bytes_used++;
        if (grp_pos == srcd_pkg::POS_HIGH) begin
            hi_byte = b;
            crc_acc = crc8_step(crc_acc, b);
            grp_pos = srcd_pkg::POS_LOW;
            return 1'b0;
        end
        if (grp_pos == srcd_pkg::POS_LOW) begin
            lo_byte = b;
            crc_acc = crc8_step(crc_acc, b);
            grp_pos = srcd_pkg::POS_CRC;
            return 1'b0;
        end

        w = {hi_byte, lo_byte};
        r.word_index = words_done[2:0];
        r.raw_word   = w;
        r.crc_ok     = (crc_acc == b);
        if (!r.crc_ok) crc_fail_seen = 1'b1;
        r.last = (words_done + 4'd1 == frame_len);

        if (kind_shadow == srcd_pkg::KIND_LONG) begin
            if (words_done == 4'd0) upper_half = w;
            else r.long_value = {upper_half, w};
        end else if (words_done[2:0] <= srcd_pkg::IDX_LAST_UNSIGNED) begin
            if (w == srcd_pkg::SENT_UNSIGNED) begin
                r.unavailable  = 1'b1;
                r.scaled_value = srcd_pkg::SENT_SCALED;
            end else begin
                r.scaled_value = 22'(int'(w) * 20);
            end
        end else if (w == srcd_pkg::SENT_SIGNED) begin
            r.unavailable  = 1'b1;
            r.scaled_value = srcd_pkg::SENT_SCALED;
        end else begin
            s = int'($signed(w));
            if (words_done[2:0] == srcd_pkg::IDX_DIV100) r.scaled_value = 22'(s * 2);
            else if (words_done[2:0] == srcd_pkg::IDX_DIV200) r.scaled_value = 22'(s);
            else r.scaled_value = 22'(s * 20);
        end

        r.frame_ok = r.last && !crc_fail_seen;
        words_done = words_done + 4'd1;
        grp_pos    = srcd_pkg::POS_HIGH;
        crc_acc    = srcd_pkg::CRC_INIT;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Word channel: receiver stalls and result checking
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        word_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request != 0) begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                word_ch.ready <= 1'b0;
            end else begin
                word_ch.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_word_result want;
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual raw %0h",
                         $time, word_ch.raw_word);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("word_index",   32'(want.word_index),  32'(word_ch.word_index));
                check_field("raw_word",     32'(want.raw_word),    32'(word_ch.raw_word));
                check_field("crc_ok",       32'(want.crc_ok),      32'(word_ch.crc_ok));
                check_field("unavailable",  32'(want.unavailable), 32'(word_ch.unavailable));
                check_field("scaled_value", 32'(want.scaled_value[21:0]),
                            32'(word_ch.scaled_value[21:0]));
                check_field("long_value",   want.long_value,       word_ch.long_value);
                check_field("frame_ok",     32'(want.frame_ok),    32'(word_ch.frame_ok));
                check_field("last",         32'(want.last),        32'(word_ch.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte channel and register helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic start_flag, input logic [7:0] b);
        t_word_result r;
        while ($urandom_range(99) < idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.first     <= start_flag;
        byte_ch.data_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        if (deframe_byte(start_flag, b, r)) expected_words.push_back(r);
    endtask

    task automatic send_word(input logic start_flag, input logic [15:0] w,
                             input bit good_crc);
        logic [7:0] c;
        c = crc8_step(crc8_step(srcd_pkg::CRC_INIT, w[15:8]), w[7:0]);
        if (!good_crc) c ^= 8'($urandom_range(1, 255));
        send_byte(start_flag, w[15:8]);
        send_byte(1'b0, w[7:0]);
        send_byte(1'b0, c);
    endtask

    // Drop valid, wait for every pending word, then let in-flight bytes settle.
    task automatic wait_idle(input int settle);
        byte_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_kind(input logic k);
        wait_idle(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        kind_shadow = k;
    endtask

    function automatic logic [15:0] pick_word();
        if ($urandom_range(3) != 0) return 16'($urandom_range(16'hFFFF));
        case ($urandom_range(6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'hFFFE;
            5: return 16'h7FFE;
            default: return 16'h0001;
        endcase
    endfunction

    // One frame of random words; optionally switch kind partway or cut it short.
    task automatic send_frame(input bit may_flip, input bit may_cut);
        int n_words;
        int flip_at;
        n_words = (kind_shadow == srcd_pkg::KIND_LONG) ? int'(srcd_pkg::LONG_WORDS)
                                                       : int'(srcd_pkg::MEAS_WORDS);
        flip_at = may_flip ? $urandom_range(1, n_words - 1) : -1;
        if (may_cut) n_words = $urandom_range(0, n_words - 1);
        for (int w = 0; w < n_words; w++) begin
            if (w == flip_at) begin
                set_kind(~kind_shadow);
                n_words = (kind_shadow == srcd_pkg::KIND_LONG) ? int'(srcd_pkg::LONG_WORDS)
                                                               : int'(srcd_pkg::MEAS_WORDS);
            end
            send_word(w == 0, pick_word(), $urandom_range(9) != 0);
        end
        // stray bytes: a partial word when cut, ignored trailers otherwise
        if (may_cut) begin
            repeat ($urandom_range(0, 2))
                send_byte(n_words == 0, 8'($urandom_range(255)));
        end else if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_out_of_frame_bytes();
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
    endtask

    task automatic test_measurement_frame();
        send_word(1'b1, 16'hFFFF, 1'b1);   // particulate sentinel
        send_word(1'b0, 16'h0000, 1'b1);
        send_word(1'b0, 16'hFFFE, 1'b0);   // largest unsigned, bad CRC
        send_word(1'b0, 16'h7FFF, 1'b1);   // not a sentinel on an unsigned word
        send_word(1'b0, 16'h7FFF, 1'b1);   // signed sentinel
        send_word(1'b0, 16'hFFFF, 1'b1);
        send_word(1'b0, 16'h8000, 1'b1);
        send_word(1'b0, 16'h7FFE, 1'b1);
        send_byte(1'b0, 8'hA5);            // past the end: ignored
    endtask

    task automatic test_long_frame();
        set_kind(srcd_pkg::KIND_LONG);
        // partial word, then restart
        send_byte(1'b1, 8'hAA);
        send_byte(1'b0, 8'h55);
        send_word(1'b1, 16'hFFFF, 1'b1);
        send_word(1'b0, 16'hFFFF, 1'b1);
    endtask

    task automatic test_backpressure();
        set_kind(srcd_pkg::KIND_MEAS);
        hold_off_request = 400;
        repeat (2) send_frame(1'b0, 1'b0);
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        target = bytes_used + 1000;
        while (bytes_used < target) begin
            // quiet stretch with no idling on either side
            idle_pct = (bytes_used > target - 600 && bytes_used < target - 350) ? 0 : 10;
            pick = $urandom_range(99);
            if (pick < 6) begin
                set_kind(logic'($urandom_range(1)));
            end else if (pick < 14) begin
                repeat ($urandom_range(1, 6))
                    send_byte($urandom_range(9) == 0, 8'($urandom_range(255)));
            end else if (pick < 24) begin
                send_frame(1'b1, 1'b0);
            end else if (pick < 34) begin
                send_frame(1'b0, 1'b1);
            end else begin
                send_frame(1'b0, 1'b0);
            end
        end
        idle_pct = 10;
    endtask

    initial begin
        byte_ch.valid     = 1'b0;
        byte_ch.first     = 1'b0;
        byte_ch.data_byte = 8'h00;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_out_of_frame_bytes();
        test_measurement_frame();
        test_long_frame();
        test_backpressure();
        test_random_traffic();

        wait_idle(TAIL_CYCLES);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
